>>> rtl/icd_pkg.sv
// ----------------------------------------------------------------------------
// icd_pkg: shared types and constants of the input command deframer
// Header codes, frame lengths, command kinds and the command item that
// travels from the frame parser through the queue to the output stage.
// ----------------------------------------------------------------------------
package icd_pkg;

    // Header bytes that open a frame.
    localparam logic [7:0] HDR_KEY_PRESS   = 8'hC1;
    localparam logic [7:0] HDR_KEY_RELEASE = 8'hC2;
    localparam logic [7:0] HDR_RELATIVE    = 8'hC3;
    localparam logic [7:0] HDR_EXACT       = 8'hC4;
    localparam logic [7:0] HDR_WHEEL       = 8'hC5;

    // Byte position of the last byte of each frame, header at position zero.
    localparam logic [3:0] KEY_LAST_POS = 4'd4;
    localparam logic [3:0] PTR_LAST_POS = 4'd10;

    // Byte positions of the fields inside a frame.
    localparam logic [3:0] POS_ID      = 4'd1;
    localparam logic [3:0] POS_KEY     = 4'd2;
    localparam logic [3:0] POS_X_FIRST = 4'd2;
    localparam logic [3:0] POS_X_LAST  = 4'd5;
    localparam logic [3:0] POS_Y_FIRST = 4'd6;
    localparam logic [3:0] POS_Y_LAST  = 4'd9;

    // Command kinds reported on the output.
    localparam logic [2:0] KIND_PRESS    = 3'd0;
    localparam logic [2:0] KIND_RELEASE  = 3'd1;
    localparam logic [2:0] KIND_EXACT    = 3'd2;
    localparam logic [2:0] KIND_RELATIVE = 3'd3;
    localparam logic [2:0] KIND_WHEEL    = 3'd4;

    // Frame classes of a header byte.
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_KEY  = 2'd1;
    localparam logic [1:0] CLASS_PTR  = 2'd2;

    // Default depth of the queue between parser and output stage.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One decoded command.
    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         id;
        logic [7:0]         key;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } icd_cmd_t;

    // Frame class of a byte taken as a header.
    function automatic logic [1:0] hdr_class(input logic [7:0] b);
        logic [1:0] cls;
        case (b) inside
            HDR_KEY_PRESS, HDR_KEY_RELEASE:         cls = CLASS_KEY;
            HDR_RELATIVE, HDR_EXACT, HDR_WHEEL:     cls = CLASS_PTR;
            default:                                cls = CLASS_NONE;
        endcase
        return cls;
    endfunction

    // Command kind that a header reports.
    function automatic logic [2:0] hdr_kind(input logic [7:0] b);
        logic [2:0] kind;
        case (b)
            HDR_KEY_PRESS:   kind = KIND_PRESS;
            HDR_KEY_RELEASE: kind = KIND_RELEASE;
            HDR_EXACT:       kind = KIND_EXACT;
            HDR_RELATIVE:    kind = KIND_RELATIVE;
            default:         kind = KIND_WHEEL;
        endcase
        return kind;
    endfunction

endpackage

>>> rtl/icd_parser.sv
// ----------------------------------------------------------------------------
// icd_parser: frame parser of the input command deframer
// Takes one byte per cycle while byte_accept is set, tracks the open frame,
// collects its fields and pushes one command into the queue at frame end.
// ----------------------------------------------------------------------------
module icd_parser
    import icd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_accept,
    input  logic [7:0] rx_byte,
    output logic     push,
    output icd_cmd_t push_cmd
);

    logic [7:0]         header_reg, header_next;
    logic [3:0]         count_reg, count_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         key_reg, key_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic [1:0]         open_class;

    assign open_class = hdr_class(header_reg);

    // Frame tracking and field collection.
    always_comb
    begin
        header_next = header_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        key_next    = key_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        push        = 1'b0;
        push_cmd    = '0;
        if (byte_accept)
        begin
            unique case (open_class)
                CLASS_KEY:
                begin
                    if (count_reg == POS_ID)
                    begin
                        id_next = rx_byte;
                    end
                    else if (count_reg == POS_KEY)
                    begin
                        key_next = rx_byte;
                    end
                    if (count_reg >= KEY_LAST_POS)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = hdr_kind(header_reg);
                        push_cmd.id   = id_reg;
                        push_cmd.key  = key_reg;
                        header_next   = '0;
                        count_next    = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 4'd1;
                    end
                end
                CLASS_PTR:
                begin
                    if (count_reg == POS_ID)
                    begin
                        id_next = rx_byte;
                    end
                    else if (count_reg >= POS_X_FIRST && count_reg <= POS_X_LAST)
                    begin
                        x_next = {x_reg[23:0], rx_byte};
                    end
                    else if (count_reg >= POS_Y_FIRST && count_reg <= POS_Y_LAST)
                    begin
                        y_next = {y_reg[23:0], rx_byte};
                    end
                    if (count_reg >= PTR_LAST_POS)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = hdr_kind(header_reg);
                        push_cmd.id   = id_reg;
                        push_cmd.x    = x_reg;
                        push_cmd.y    = y_reg;
                        header_next   = '0;
                        count_next    = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 4'd1;
                    end
                end
                default:
                begin
                    // No frame open: keep only a known header byte.
                    if (hdr_class(rx_byte) != CLASS_NONE)
                    begin
                        header_next = rx_byte;
                        count_next  = 4'd1;
                    end
                    else
                    begin
                        header_next = '0;
                        count_next  = '0;
                    end
                end
            endcase
        end
    end

    // Frame control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            header_reg <= header_next;
            count_reg  <= count_next;
        end
    end

    // Collected fields.
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

`ifndef SYNTH
    // A frame is open exactly when the byte count is nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (header_reg == 8'h00) == (count_reg == 4'd0))
        else $error("icd_parser: header and byte count disagree");

    // The count never passes the last position of the open frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (open_class != CLASS_KEY || count_reg <= KEY_LAST_POS) &&
        (open_class != CLASS_PTR || count_reg <= PTR_LAST_POS))
        else $error("icd_parser: byte count beyond frame end");

    // A command leaves the parser only from an open frame, which then closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (open_class != CLASS_NONE) ##1 (header_reg == 8'h00))
        else $error("icd_parser: command without a properly closed frame");
`endif

endmodule

>>> rtl/icd_queue.sv
// ----------------------------------------------------------------------------
// icd_queue: command queue of the input command deframer
// A short first-in first-out queue of decoded commands that lets the parser
// and the output stage stall independently.
// ----------------------------------------------------------------------------
module icd_queue
    import icd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  icd_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output icd_cmd_t head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    icd_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    // The producer never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("icd_queue: push while full");

    // The consumer never reads an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("icd_queue: pop while empty");

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("icd_queue: fill count beyond depth");
`endif

endmodule

>>> rtl/icd_out_stage.sv
// ----------------------------------------------------------------------------
// icd_out_stage: output register of the input command deframer
// Holds the command on the output channel and refills from the queue
// whenever the register is empty or its item is being taken.
// ----------------------------------------------------------------------------
module icd_out_stage
    import icd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  icd_cmd_t q_head,
    output logic     q_pop,
    output logic     out_valid,
    input  logic     out_stall,
    output icd_cmd_t out_cmd
);

    logic     valid_reg, valid_next;
    icd_cmd_t cmd_reg;

    // Load the next command when the register is free this cycle.
    assign q_pop      = !q_empty && (!valid_reg || !out_stall);
    assign valid_next = q_pop ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

endmodule

>>> rtl/input_command_deframer.sv
// ----------------------------------------------------------------------------
// input_command_deframer: remote-input command frame decoder
// Decodes key frames and pointer frames from a received byte stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle on the input channel and
// reports one command for each complete frame: a 5-byte key frame (headers
// 0xC1, 0xC2) or an 11-byte pointer frame (headers 0xC3, 0xC4, 0xC5). Bytes
// outside a frame that are not a known header are dropped; checksum and
// reserved bytes are consumed without a check. The parser updates its frame
// state for each accepted byte, so input bytes are taken back to back.
// The command queue takes a command at the edge that accepts the last byte of
// its frame; the output register loads it from the queue when the register is
// empty or its command is being taken, and then shows it on the output.
// The input stalls only while the command queue is full, which happens only
// when the output side holds off commands; with a free output the sustained
// rate is one byte per cycle.
module input_command_deframer
    import icd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         command_kind,
    output logic [7:0]         message_id,
    output logic [7:0]         key_code,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y
);

    logic     byte_accept;
    logic     push;
    icd_cmd_t push_cmd;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    icd_cmd_t q_head;
    icd_cmd_t out_cmd;

    assign in_stall    = q_full;
    assign byte_accept = in_valid && !in_stall;

    // Front: frame parser.
    icd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Command queue between parser and output.
    icd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (q_head)
    );

    // Back: output register.
    icd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_cmd   (out_cmd)
    );

    assign command_kind = out_cmd.kind;
    assign message_id   = out_cmd.id;
    assign key_code     = out_cmd.key;
    assign pos_x        = out_cmd.x;
    assign pos_y        = out_cmd.y;

endmodule

>>> dv/input_command_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_command_deframer_tb: self-checking bench of the command deframer
// A byte stream of directed frames, then random well-formed frames mixed with
// noise and cut-off frames, is sent with random gaps while the output side
// stalls at random. Each accepted command is compared field by field with the
// oldest prediction, pinned in the directed table or made by a bench frame parser.
// ----------------------------------------------------------------------------
module input_command_deframer_tb;
    import icd_pkg::*;

    // Framed bytes to send in the random part.
    localparam int RANDOM_BYTES = 1500;
    // Framed bytes between two full drains of the command queue.
    localparam int DRAIN_EVERY  = 400;
    // Cycles to wait after the last command has come back.
    localparam int TAIL_CYCLES  = 16;
    // Run time after which the bench gives up.
    localparam int RUN_LIMIT_NS = 2_000_000;
    // Slots of the ring that holds predicted commands.
    localparam int PEND_DEPTH   = 1024;

    // One row of the directed stimulus table; cmd is used only when pinned.
    typedef struct packed {
        logic [7:0] b;
        logic       pinned;
        icd_cmd_t   cmd;
    } stim_row_t;

    localparam icd_cmd_t NO_CMD = '0;
    localparam int       NUM_ROWS = 45;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Unknown bytes outside a frame are dropped.
        '{8'h00, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        // Key press; a header byte in the reserved slot is plain data.
        '{HDR_KEY_PRESS, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{HDR_WHEEL, 1'b0, NO_CMD},
        '{8'h00, 1'b1, '{KIND_PRESS, 8'hFF, 8'h00, 32'sd0, 32'sd0}},
        // Key release with an all-ones key code and a zero id.
        '{HDR_KEY_RELEASE, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'hFF, 1'b1, '{KIND_RELEASE, 8'h00, 8'hFF, 32'sd0, 32'sd0}},
        // Exact position at the signed extremes.
        '{HDR_EXACT, 1'b0, NO_CMD},
        '{8'h5A, 1'b0, NO_CMD},
        '{8'h7F, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'h80, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{HDR_KEY_PRESS, 1'b1,
          '{KIND_EXACT, 8'h5A, 8'h00, 32'sh7FFF_FFFF, 32'sh8000_0000}},
        // Relative move of minus one and plus one, reported as it is.
        '{HDR_RELATIVE, 1'b0, NO_CMD},
        '{8'h01, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{8'h00, 1'b0, NO_CMD},
        '{8'h01, 1'b0, NO_CMD},
        '{8'h00, 1'b1, '{KIND_RELATIVE, 8'h01, 8'h00, -32'sd1, 32'sd1}},
        // Wheel frame, checked against the predictor.
        '{HDR_WHEEL, 1'b0, NO_CMD},
        '{8'h80, 1'b0, NO_CMD},
        '{8'h12, 1'b0, NO_CMD},
        '{8'h34, 1'b0, NO_CMD},
        '{8'h56, 1'b0, NO_CMD},
        '{8'h78, 1'b0, NO_CMD},
        '{8'hA5, 1'b0, NO_CMD},
        '{8'h5A, 1'b0, NO_CMD},
        '{8'hC3, 1'b0, NO_CMD},
        '{8'h3C, 1'b0, NO_CMD},
        '{HDR_RELATIVE, 1'b0, NO_CMD}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         command_kind;
    logic [7:0]         message_id;
    logic [7:0]         key_code;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;

    // Pinned expectation that travels along with the driven byte.
    logic               cmd_pinned = 1'b0;
    icd_cmd_t           pinned_cmd = '0;

    // Predicted commands not yet seen on the output, kept in a ring.
    icd_cmd_t pending_cmds [PEND_DEPTH];
    int       pend_wr = 0;
    int       pend_rd = 0;
    int       errors = 0;
    int       framed_bytes = 0;
    bit       no_idle = 1'b0;

    // Frame parser state of the predictor.
    logic [7:0]  open_hdr = 8'h00;
    logic [3:0]  frame_pos = 4'd0;
    logic [7:0]  id_acc = 8'h00;
    logic [7:0]  key_acc = 8'h00;
    logic [31:0] x_acc = 32'h0;
    logic [31:0] y_acc = 32'h0;

    input_command_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command_kind (command_kind),
        .message_id   (message_id),
        .key_code     (key_code),
        .pos_x        (pos_x),
        .pos_y        (pos_y)
    );

    always #1 clk = ~clk;

    function automatic bit is_key_hdr(input logic [7:0] b);
        return b == HDR_KEY_PRESS || b == HDR_KEY_RELEASE;
    endfunction

    function automatic bit is_ptr_hdr(input logic [7:0] b);
        return b == HDR_EXACT || b == HDR_RELATIVE || b == HDR_WHEEL;
    endfunction

    // Number of predicted commands still waiting for the output.
    function automatic int pend_count();
        return pend_wr - pend_rd;
    endfunction

    function automatic void close_frame();
        open_hdr  = 8'h00;
        frame_pos = 4'd0;
        id_acc    = 8'h00;
        key_acc   = 8'h00;
        x_acc     = 32'h0;
        y_acc     = 32'h0;
    endfunction

    // Advances the parser by one byte; returns 1 when a frame completes.
    function automatic bit deframe_byte(input logic [7:0] b, output icd_cmd_t cmd);
        cmd = '0;
        // No frame open: only a known header opens one.
        if (!is_key_hdr(open_hdr) && !is_ptr_hdr(open_hdr))
        begin
            close_frame();
            if (is_key_hdr(b) || is_ptr_hdr(b))
            begin
                open_hdr     = b;
                frame_pos    = 4'd1;
                framed_bytes = framed_bytes + 1;
            end
            return 1'b0;
        end
        framed_bytes = framed_bytes + 1;
        if (is_key_hdr(open_hdr))
        begin
            if (frame_pos == POS_ID)
                id_acc = b;
            else if (frame_pos == POS_KEY)
                key_acc = b;
            if (frame_pos == KEY_LAST_POS)
            begin
                cmd.kind = (open_hdr == HDR_KEY_PRESS) ? KIND_PRESS : KIND_RELEASE;
                cmd.id   = id_acc;
                cmd.key  = key_acc;
                close_frame();
                return 1'b1;
            end
        end
        else
        begin
            if (frame_pos == POS_ID)
                id_acc = b;
            else if (frame_pos >= POS_X_FIRST && frame_pos <= POS_X_LAST)
                x_acc = {x_acc[23:0], b};
            else if (frame_pos >= POS_Y_FIRST && frame_pos <= POS_Y_LAST)
                y_acc = {y_acc[23:0], b};
            if (frame_pos == PTR_LAST_POS)
            begin
                if (open_hdr == HDR_EXACT)
                    cmd.kind = KIND_EXACT;
                else if (open_hdr == HDR_RELATIVE)
                    cmd.kind = KIND_RELATIVE;
                else
                    cmd.kind = KIND_WHEEL;
                cmd.id = id_acc;
                cmd.x  = x_acc;
                cmd.y  = y_acc;
                close_frame();
                return 1'b1;
            end
        end
        frame_pos = frame_pos + 4'd1;
        return 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Frame content biased toward header codes and the byte extremes.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 8'hC1 + 8'($urandom_range(0, 4));
        else if (r < 18)
            return 8'h00;
        else if (r < 24)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Drives one item and waits until the block takes it.
    task automatic push_byte(input logic [7:0] b, input logic pin, input icd_cmd_t cmd);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        rx_byte    <= b;
        cmd_pinned <= pin;
        pinned_cmd <= cmd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Sends one frame with random content, cut short if len_cut is set.
    task automatic send_frame(input bit len_cut);
        logic [7:0] hdr;
        int         len;
        hdr = 8'hC1 + 8'($urandom_range(0, 4));
        len = is_key_hdr(hdr) ? int'(KEY_LAST_POS) + 1 : int'(PTR_LAST_POS) + 1;
        if (len_cut)
            len = $urandom_range(1, len - 1);
        push_byte(hdr, 1'b0, NO_CMD);
        for (int i = 1; i < len; i++)
            push_byte(pick_byte(), 1'b0, NO_CMD);
    endtask

    // Input side: predict on every accepted item.
    always @(posedge clk)
    begin : input_monitor
        icd_cmd_t cmd;
        bit       done;
        if (rst_n && in_valid && !in_stall)
        begin
            done = deframe_byte(rx_byte, cmd);
            if (done || cmd_pinned)
            begin
                pending_cmds[pend_wr % PEND_DEPTH] = cmd_pinned ? pinned_cmd : cmd;
                pend_wr++;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected 0x%h, actual 0x%h",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Output side: compare each accepted command with the oldest prediction.
    always @(posedge clk)
    begin : output_monitor
        icd_cmd_t exp_cmd;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pend_count() == 0)
            begin
                $display("%0t: unexpected command: expected none, actual kind %0d id 0x%h",
                         $time, command_kind, message_id);
                errors++;
            end
            else
            begin
                exp_cmd = pending_cmds[pend_rd % PEND_DEPTH];
                pend_rd++;
                check_field("command_kind", 32'(exp_cmd.kind), 32'(command_kind));
                check_field("message_id", 32'(exp_cmd.id), 32'(message_id));
                check_field("key_code", 32'(exp_cmd.key), 32'(key_code));
                check_field("pos_x", exp_cmd.x, pos_x);
                check_field("pos_y", exp_cmd.y, pos_y);
            end
        end
    end

    // Output stall: runs of random length, held level within a run.
    always @(posedge clk)
    begin : stall_gen
        int  run_left;
        bit  stall_lvl;
        int  r;
        if (run_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 50)
            begin
                stall_lvl = 1'b0;
                run_left  = $urandom_range(1, 8);
            end
            else if (r < 85)
            begin
                stall_lvl = 1'b1;
                run_left  = $urandom_range(1, 3);
            end
            else if (r < 97)
            begin
                stall_lvl = 1'b1;
                run_left  = $urandom_range(4, 12);
            end
            else
            begin
                stall_lvl = 1'b1;
                run_left  = $urandom_range(20, 60);
            end
        end
        else
            run_left--;
        out_stall <= stall_lvl;
    end

    // Guard against a hung run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        int start_bytes;
        int next_drain;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int i = 0; i < NUM_ROWS; i++)
            push_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].cmd);

        // Random frames with noise and cut-off frames in between.
        start_bytes = framed_bytes;
        next_drain  = start_bytes + DRAIN_EVERY;
        while (framed_bytes - start_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) push_byte(pick_byte(), 1'b0, NO_CMD);
            send_frame($urandom_range(0, 9) == 0);
            // Hold the sender off until every command has come out.
            if (framed_bytes >= next_drain)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pend_count() != 0);
                next_drain = next_drain + DRAIN_EVERY;
            end
        end

        // Drain and finish.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pend_count() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pend_count() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/icd_pkg.sv
rtl/icd_parser.sv
rtl/icd_queue.sv
rtl/icd_out_stage.sv
rtl/input_command_deframer.sv
dv/input_command_deframer_tb.sv
